[src/tsvd_pkg.sv]
`default_nettype none
package tsvd_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF       = 65536;
	localparam int MAX_CH_DEF      = 8;
	localparam int SAMPLE_BITS_DEF = 16;

	// Register file
	localparam int CC_W  = 4;   // channel_count width
	localparam int K_W   = 16;  // smoothing_k width
	localparam int CFG_W = 16;  // widest register
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_K   = 1'd1;

	localparam logic [CC_W-1:0] CC_RESET = 4'd2;
	localparam logic [K_W-1:0]  K_RESET  = 16'd64;

	// Speed in unsigned Q1.16
	localparam int SPD_W     = 17;
	localparam int FRAC_W    = 16;
	localparam logic [SPD_W-1:0] ONE_Q16 = 17'h10000;

	// speed * (k - 1) and the numerator of the speed division
	localparam int PROD_W    = SPD_W + K_W;
	localparam int SPD_NUM_W = PROD_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_MDIV_LD,
		ST_MDIV,
		ST_WRITE,
		ST_MUL,
		ST_SDIV_LD,
		ST_SDIV,
		ST_SPEED,
		ST_READ,
		ST_OUT
	} state_t;

	typedef enum logic {
		DIV_MONO,
		DIV_SPEED
	} div_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     load;
		logic     acc;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_step;
		logic     hist_wr;
		logic     mul;
		logic     speed_upd;
		logic     rd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_playing;
		logic playing;
		logic acc_last;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

[src/tsvd_ctrl.sv]
`default_nettype none
module tsvd_ctrl import tsvd_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) begin
					state_nx = sts.in_playing ? ST_ACC : ST_MUL;
				end
			end
			ST_ACC: begin
				if (sts.acc_last) begin
					state_nx = ST_MDIV_LD;
				end
			end
			ST_MDIV_LD: state_nx = ST_MDIV;
			ST_MDIV: begin
				if (sts.div_last) begin
					state_nx = ST_WRITE;
				end
			end
			ST_WRITE:   state_nx = ST_MUL;
			ST_MUL:     state_nx = ST_SDIV_LD;
			ST_SDIV_LD: state_nx = ST_SDIV;
			ST_SDIV: begin
				if (sts.div_last) begin
					state_nx = ST_SPEED;
				end
			end
			ST_SPEED:   state_nx = ST_READ;
			ST_READ:    state_nx = ST_OUT;
			ST_OUT: begin
				if (!sts.out_busy) begin
					state_nx = ST_IDLE;
				end
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_MONO;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = sts.in_valid;
			end
			ST_ACC:     cmd.acc = 1'b1;
			ST_MDIV_LD: cmd.div_start = 1'b1;
			ST_MDIV:    cmd.div_step = 1'b1;
			ST_WRITE:   cmd.hist_wr = 1'b1;
			ST_MUL:     cmd.mul = 1'b1;
			ST_SDIV_LD: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SPEED;
			end
			ST_SDIV:    cmd.div_step = 1'b1;
			ST_SPEED:   cmd.speed_upd = 1'b1;
			ST_READ:    cmd.rd = 1'b1;
			ST_OUT:     cmd.out_load = !sts.out_busy;
			default:    cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

[src/tsvd_dp.sv]
`default_nettype none
module tsvd_dp import tsvd_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int MAX_CH      = MAX_CH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int IN_W        = 136,
	parameter int OUT_W       = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  wire                  s_tvalid,
	input  wire  [IN_W-1:0]      s_tdata,
	input  wire                  s_tlast,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [OUT_W-1:0]     m_tdata,
	input  wire                  cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [CFG_W-1:0]     cfg_data
);

	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int LAG_W = AW + FRAC_W + 1;
	localparam int SW    = SB + 3;
	localparam int CW    = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;
	localparam int DW    = (SPD_NUM_W > SW) ? SPD_NUM_W : SW;
	localparam int QW    = (SPD_W > SW) ? SPD_W : SW;
	localparam int BW    = $clog2(QW);

	localparam logic signed [LAG_W-1:0] LAG_LO =
		LAG_W'(-(longint'(DEPTH - 1) * longint'(65536)));
	localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);

	// ---------------- configuration ----------------
	logic [CC_W-1:0] cc_q;
	logic [K_W-1:0]  k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_RESET;
			k_q  <= K_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL_COUNT: cc_q <= cfg_data[CC_W-1:0];
				CFG_SMOOTHING_K:   k_q  <= cfg_data[K_W-1:0];
				default: ;
			endcase
		end
	end

	logic [CC_W-1:0] n_eff;
	logic [K_W-1:0]  k_eff;

	always_comb begin
		if (cc_q == '0) begin
			n_eff = CC_W'(1);
		end else if (cc_q > CC_W'(MAX_CH)) begin
			n_eff = CC_W'(MAX_CH);
		end else begin
			n_eff = cc_q;
		end
		k_eff = (k_q == '0) ? K_W'(1) : k_q;
	end

	// ---------------- input capture ----------------
	logic [SB-1:0] samp_q [MAX_CH];
	logic          play_q;
	logic          blk_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			play_q <= s_tdata[0];
			blk_q  <= s_tlast;
			for (int c = 0; c < MAX_CH; c++) begin
				samp_q[c] <= s_tdata[1 + c*SB +: SB];
			end
		end
	end

	// ---------------- channel sum ----------------
	logic signed [SW-1:0] sum_q;
	logic [CW-1:0]        ch_q;
	logic [SW-1:0]        abs_sum;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= '0;
			ch_q  <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SW'($signed(samp_q[ch_q]));
			ch_q  <= ch_q + CW'(1);
		end
	end

	assign abs_sum = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	// ---------------- speed product ----------------
	logic [SPD_W-1:0]     speed_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SPD_NUM_W-1:0] spd_num;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(speed_q * (k_eff - K_W'(1)));
		end
	end

	assign spd_num = play_q
		? SPD_NUM_W'(prod_q) + SPD_NUM_W'(ONE_Q16) + SPD_NUM_W'(k_eff) - SPD_NUM_W'(1)
		: SPD_NUM_W'(prod_q);

	// ---------------- shared bit-serial divider ----------------
	logic [DW-1:0]  div_num_q;
	logic [K_W-1:0] div_den_q;
	logic [K_W-1:0] div_rem_q;
	logic [QW-1:0]  div_quo_q;
	logic [BW-1:0]  div_bit_q;
	logic [K_W:0]   trial;

	assign trial = {div_rem_q, div_num_q[div_bit_q]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_quo_q <= '0;
			if (cmd.div_sel == DIV_MONO) begin
				div_num_q <= DW'(abs_sum);
				div_den_q <= K_W'(n_eff);
				div_rem_q <= '0;
				div_bit_q <= BW'(SW - 1);
			end else begin
				div_num_q <= DW'(spd_num);
				div_den_q <= k_eff;
				div_rem_q <= K_W'(spd_num >> SPD_W);
				div_bit_q <= BW'(SPD_W - 1);
			end
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, div_den_q}) begin
				div_rem_q            <= K_W'(trial - {1'b0, div_den_q});
				div_quo_q[div_bit_q] <= 1'b1;
			end else begin
				div_rem_q <= trial[K_W-1:0];
			end
			div_bit_q <= div_bit_q - BW'(1);
		end
	end

	// ---------------- speed, lag, write pointer ----------------
	logic signed [LAG_W-1:0] lag_q;
	logic [AW-1:0]           wp_q;
	logic [AW:0]             fill_q;
	logic [AW-1:0]           wp_nx;
	logic [SB-1:0]           mono;
	logic signed [LAG_W:0]   lag_dn;
	logic signed [LAG_W:0]   lag_up;
	logic [SPD_W-1:0]        spd_new;
	logic [LAG_W-1:0]        lag_neg;
	logic [AW-1:0]           ti;
	logic [AW:0]             idx_wide;
	logic [AW-1:0]           rd_idx;
	logic                    rd_hit;

	assign wp_nx = ({1'b0, wp_q} + (AW+1)'(1) == DEPTH_V) ? '0 : wp_q + AW'(1);
	assign mono  = sum_q[SW-1] ? SB'(-div_quo_q[SB-1:0]) : div_quo_q[SB-1:0];

	assign lag_dn  = {lag_q[LAG_W-1], lag_q} - (LAG_W+1)'(65536);
	assign spd_new = (div_quo_q[SPD_W-1:0] > ONE_Q16) ? ONE_Q16 : div_quo_q[SPD_W-1:0];
	assign lag_up  = {lag_q[LAG_W-1], lag_q} + $signed((LAG_W+1)'(spd_new));

	// lag is never positive, so its magnitude keeps AW integer bits
	assign lag_neg  = LAG_W'(-lag_q);
	assign ti       = lag_neg[LAG_W-2:FRAC_W];
	assign idx_wide = {1'b0, wp_q} + ((wp_q < ti) ? DEPTH_V : '0) - {1'b0, ti};
	assign rd_idx   = idx_wide[AW-1:0];
	assign rd_hit   = (fill_q == DEPTH_V) || ((rd_idx != '0) && ({1'b0, rd_idx} <= fill_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			lag_q   <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.hist_wr) begin
				wp_q <= wp_nx;
				if (fill_q != DEPTH_V) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
				if (lag_dn < $signed({LAG_LO[LAG_W-1], LAG_LO})) begin
					lag_q <= LAG_LO;
				end else begin
					lag_q <= lag_dn[LAG_W-1:0];
				end
			end
			if (cmd.speed_upd) begin
				speed_q <= spd_new;
				if (lag_up > 0) begin
					lag_q <= '0;
				end else begin
					lag_q <= lag_up[LAG_W-1:0];
				end
			end
			if (cmd.rd && blk_q) begin
				// drop the fraction, keep the truncated whole samples
				lag_q <= LAG_W'(-$signed({1'b0, ti, {FRAC_W{1'b0}}}));
			end
		end
	end

	// ---------------- history memory ----------------
	logic [SB-1:0] hist_mem [DEPTH];
	logic [SB-1:0] rd_data_q;
	logic          rd_hit_q;

	always_ff @(posedge clk) begin
		if (cmd.hist_wr) begin
			hist_mem[wp_nx] <= mono;
		end
		if (cmd.rd) begin
			rd_data_q <= hist_mem[rd_idx];
			rd_hit_q  <= rd_hit;
		end
	end

	// ---------------- output register ----------------
	logic          out_valid_q;
	logic [SB-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= rd_hit_q ? rd_data_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);

	always_comb begin
		sts.in_valid   = s_tvalid;
		sts.in_playing = s_tdata[0];
		sts.playing    = play_q;
		sts.acc_last   = (CC_W'(ch_q) == n_eff - CC_W'(1));
		sts.div_last   = (div_bit_q == '0);
		sts.out_busy   = out_valid_q && !m_tready;
	end

endmodule
`default_nettype wire

[src/tape_stop_varispeed_delay_core.sv]
// Tape-stop varispeed delay. Each input word is one audio frame: a play flag in
// tdata bit 0, then MAX_CHANNELS signed samples, with tlast marking the last
// frame of a processing block. Every frame gives exactly one output word, the
// mono sample played back from the history ring. While playing, the active
// channels are averaged to mono and recorded, and the playback speed ramps
// toward 1.0; while paused nothing is recorded and the speed decays to 0, so
// the playback slows to a stop like a tape. The active channels number
// channel_count limited to 1 .. MAX_CHANNELS. Frames are handled one at a
// time: the sequencer accepts a frame only while idle and goes back to idle
// once the frame's result is in the output register. The two divisions
// (mono average, then speed smoothing) share one bit-serial divider that
// retires one quotient bit per cycle. The output register lets the next
// frame be accepted while a result waits. Configuration (register 0
// channel_count, register 1 smoothing_k) is to be written only while no
// frame is in flight; the core itself does not enforce this. The history
// memory needs no clearing pass: a fill count makes entries never written
// read as zero.
`default_nettype none
module tape_stop_varispeed_delay_core import tsvd_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int MAX_CH      = MAX_CH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// slave side: frames in
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// tdata: playing, sample_0 .. sample_(MAX_CH-1), zero pad to bytes
	input  wire  [((1 + MAX_CH*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  wire                  s_tlast,   // block_end
	// master side: playback samples out
	output logic                 m_tvalid,
	input  wire                  m_tready,
	// tdata: out_sample, zero pad to bytes
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// register writes
	input  wire                  cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [CFG_W-1:0]     cfg_data
);

	localparam int IN_W  = ((1 + MAX_CH*SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

	cmd_t cmd;
	sts_t sts;

	// Sequence one frame: sum, divide and record (playing frames only), smooth the speed, move the lag, read.
	tsvd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Hold the registers, the divider, the history memory and the output word.
	tsvd_dp #(
		.DEPTH       (DEPTH),
		.MAX_CH      (MAX_CH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IN_W        (IN_W),
		.OUT_W       (OUT_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Accept a word only while the sequencer is idle.
	assign s_tready = cmd.in_ready;

endmodule
`default_nettype wire

[src/tsvd_chk.sv]
`default_nettype none
module tsvd_chk #(
	parameter int OUT_W = 16
) (
	input wire             clk,
	input wire             arst_n,
	input wire             s_tvalid,
	input wire             s_tready,
	input wire             m_tvalid,
	input wire             m_tready,
	input wire [OUT_W-1:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// one frame at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input accepted while a frame is in work");

	// at most one finished and one in-flight frame
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many frames in flight");

	// no result without a frame behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("output word without a pending frame");

endmodule

bind tape_stop_varispeed_delay_core tsvd_chk #(.OUT_W(OUT_W)) u_tsvd_chk (.*);
`default_nettype wire

[verif/tsvd_playback_checker.sv]
`timescale 1ns / 100ps
module tsvd_playback_checker import tsvd_pkg::*; #(
	parameter int S_DATA_W = 136,
	parameter int M_DATA_W = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	input  wire                 s_tready,
	input  wire  [S_DATA_W-1:0] s_tdata,
	input  wire                 s_tlast,
	input  wire                 m_tvalid,
	input  wire                 m_tready,
	input  wire  [M_DATA_W-1:0] m_tdata,
	input  wire                 cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [CFG_W-1:0]    cfg_data,
	output int                  fail_count,
	output int                  words_due
);

	localparam int PTR_W = $clog2(DEPTH_DEF);
	localparam longint LAG_FLOOR = -(longint'(DEPTH_DEF) - 1) * 65536;
	localparam longint UNITY = 65536;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

	// shadow of the recorder state
	sample_t          tape [DEPTH_DEF];
	logic [PTR_W-1:0] head;
	longint           lag;
	logic [SPD_W-1:0] speed;
	logic [CC_W-1:0]  chan_count;
	logic [K_W-1:0]   smooth_k;

	sample_t playback_due [$];
	sample_t got_word;
	int      mismatches = 0;

	function automatic longint clamp_lag(longint v);
		if (v > 0)
			return 0;
		if (v < LAG_FLOOR)
			return LAG_FLOOR;
		return v;
	endfunction

	// record (when playing), ramp the speed, move the lag, read the tape
	function automatic sample_t predict_playback(logic play, logic last,
			logic [MAX_CH_DEF*SAMPLE_BITS_DEF-1:0] chans);
		longint k, n, total, num, nxt, whole;
		logic [PTR_W-1:0] rd_ptr;
		k = (smooth_k == 0) ? 1 : longint'(smooth_k);
		if (play) begin
			n = (chan_count == 0) ? 1 :
				(chan_count > MAX_CH_DEF) ? MAX_CH_DEF : longint'(chan_count);
			total = 0;
			for (longint c = 0; c < n; c++)
				total += longint'($signed(chans[c*SAMPLE_BITS_DEF +: SAMPLE_BITS_DEF]));
			head = head + 1'b1;
			tape[head] = sample_t'(total / n);
			lag = clamp_lag(lag - UNITY);
		end
		num = longint'(speed) * (k - 1);
		nxt = play ? (num + UNITY + k - 1) / k : num / k;
		if (nxt > UNITY)
			nxt = UNITY;
		speed = nxt[SPD_W-1:0];
		lag = clamp_lag(lag + nxt);
		whole = lag / UNITY;
		rd_ptr = head + whole[PTR_W-1:0];
		if (last)
			lag = whole * UNITY;
		return tape[rd_ptr];
	endfunction

	task automatic flag_word(bit had_due, sample_t want, sample_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (had_due)
				$display("%0t: out_sample mismatch: expected %0d, got %0d", $realtime, want, got);
			else
				$display("%0t: out_sample %0d arrived with no frame waiting", $realtime, got);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			foreach (tape[i])
				tape[i] = '0;
			head = '0;
			lag = 0;
			speed = '0;
			chan_count = CC_RESET;
			smooth_k = K_RESET;
			playback_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNEL_COUNT: chan_count = cfg_data[CC_W-1:0];
					CFG_SMOOTHING_K:   smooth_k = cfg_data[K_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_word = m_tdata[SAMPLE_BITS_DEF-1:0];
				if (playback_due.size() == 0)
					flag_word(1'b0, '0, got_word);
				else if (got_word !== playback_due[0])
					flag_word(1'b1, playback_due.pop_front(), got_word);
				else
					void'(playback_due.pop_front());
			end
			if (s_tvalid && s_tready)
				playback_due.push_back(predict_playback(s_tdata[0], s_tlast,
					s_tdata[1 +: MAX_CH_DEF*SAMPLE_BITS_DEF]));
		end
		words_due <= playback_due.size();
		fail_count <= mismatches;
	end

endmodule

[verif/tb_tape_stop_varispeed_delay_core.sv]
`timescale 1ns / 100ps
module tb_tape_stop_varispeed_delay_core;
	import tsvd_pkg::*;

	localparam int S_DATA_W = ((1 + MAX_CH_DEF*SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int M_DATA_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8;

	// Random part: six register settings, this many frames under each
	localparam int PHASES          = 6;
	localparam int FRAMES_PER_PHASE = 175;
	// Receiver hold-off long enough that the core backs up into its input
	localparam int HOLD_CYCLES     = 400;
	// Margin to wait after the drain before the verdict is given
	localparam int SETTLE_CYCLES   = 100;
	// Cycles without any word moving before the run is declared hung
	localparam int IDLE_LIMIT      = 20000;

	localparam logic [SAMPLE_BITS_DEF-1:0] S_MIN = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};
	localparam logic [SAMPLE_BITS_DEF-1:0] S_MAX = ~S_MIN;

	typedef logic [MAX_CH_DEF-1:0][SAMPLE_BITS_DEF-1:0] chan_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// tdata: playing, sample_0 .. sample_7, zero pad to bytes
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 s_tlast = 1'b0;   // block_end

	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// tdata: out_sample, zero pad to bytes
	logic [M_DATA_W-1:0]  m_tdata;

	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CHANNEL_COUNT;
	logic [CFG_W-1:0]     cfg_data = '0;

	int fail_count;
	int words_due;
	int idle_cycles = 0;

	// Traffic shaping knobs: steady sides never idle, the hold request
	// makes the receiver back off for HOLD_CYCLES on its own count
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_req = 1'b0;

	always #4 clk = ~clk;

	tape_stop_varispeed_delay_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tsvd_playback_checker #(
		.S_DATA_W(S_DATA_W),
		.M_DATA_W(M_DATA_W)
	) playback_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.words_due (words_due)
	);

	// Bias samples toward the corners of the range, otherwise uniform
	function automatic chan_set_t random_chans();
		chan_set_t chans;
		for (int c = 0; c < MAX_CH_DEF; c++) begin
			case ($urandom_range(15))
				0: chans[c] = S_MIN;
				1: chans[c] = S_MAX;
				2: chans[c] = '0;
				3: chans[c] = '1;
				default: chans[c] = SAMPLE_BITS_DEF'($urandom);
			endcase
		end
		return chans;
	endfunction

	// Offer one frame word and hold it until the core takes it. Valid stays
	// high on return so back-to-back frames go out without a bubble.
	task automatic send_frame(logic play, logic last, chan_set_t chans);
		if (!tx_steady && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		s_tdata <= S_DATA_W'({chans, play});
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		repeat (8) @(posedge clk);
	endtask

	// Write both registers back to back; only called with the core idle
	task automatic configure(logic [CC_W-1:0] cc, logic [K_W-1:0] k);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHANNEL_COUNT;
		cfg_data <= CFG_W'(cc);
		@(posedge clk);
		cfg_index <= CFG_SMOOTHING_K;
		cfg_data <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: ready drops at random, 9 times in 100, unless steady;
	// a hold request parks it low for a long stretch
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				m_tready <= rx_steady || ($urandom_range(99) >= 9);
			end
		end
	end

	// Watchdog: no word moving on either side for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int  sent;
		int  run_len;
		logic play;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings first (two channels, k = 64):
		// full-scale averages, rounding of odd sums toward zero
		send_frame(1'b1, 1'b0, {MAX_CH_DEF{S_MAX}});
		send_frame(1'b1, 1'b0, {MAX_CH_DEF{S_MIN}});
		send_frame(1'b1, 1'b0, {{(MAX_CH_DEF-2){16'h1234}}, S_MIN, S_MAX});
		send_frame(1'b1, 1'b0, {{(MAX_CH_DEF-2){16'h0000}}, 16'h0000, 16'hfffd});
		// pause: speed decays, nothing recorded
		send_frame(1'b0, 1'b0, random_chans());
		send_frame(1'b0, 1'b0, random_chans());
		// block end drops the lag fraction, then a pause pushes the lag
		// up against zero
		send_frame(1'b1, 1'b1, {(MAX_CH_DEF/2){16'h5555, 16'haaaa}});
		send_frame(1'b0, 1'b0, random_chans());

		// All eight channels, k = 1 so the speed jumps to its target
		wait_idle();
		configure(4'd8, 16'd1);
		send_frame(1'b1, 1'b0, {(MAX_CH_DEF/2){16'haaaa, 16'h5555}});
		send_frame(1'b1, 1'b0, {(MAX_CH_DEF/2){S_MAX, S_MIN}});
		send_frame(1'b1, 1'b1, random_chans());
		send_frame(1'b0, 1'b0, random_chans());

		// Zero channel count acts as one, zero divisor as one
		wait_idle();
		configure(4'd0, 16'd0);
		send_frame(1'b1, 1'b0, {{(MAX_CH_DEF-1){S_MAX}}, 16'h8001});
		send_frame(1'b1, 1'b1, random_chans());
		send_frame(1'b0, 1'b0, random_chans());

		// Count above the channel limit, slowest possible ramp
		wait_idle();
		configure(4'd15, 16'd65535);
		send_frame(1'b1, 1'b0, random_chans());
		send_frame(1'b1, 1'b0, random_chans());
		send_frame(1'b0, 1'b1, random_chans());
		send_frame(1'b0, 1'b0, random_chans());

		wait_idle();
		configure(4'd9, 16'd2);
		send_frame(1'b1, 1'b0, random_chans());
		send_frame(1'b1, 1'b0, random_chans());
		send_frame(1'b1, 1'b1, random_chans());
		send_frame(1'b0, 1'b0, random_chans());
		send_frame(1'b0, 1'b0, random_chans());

		// Random part: runs of playing and paused frames, the way a
		// transport is started and stopped, with blocks ending at random
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: configure(4'd1, 16'd1);
				1: configure(4'd8, 16'd65535);
				2: configure(4'($urandom_range(15)), 16'($urandom_range(1, 256)));
				3: configure(4'd3, 16'd16);
				4: configure(4'($urandom_range(15)), 16'($urandom));
				default: configure(CC_RESET, K_RESET);
			endcase
			// one phase runs with neither side ever idling
			tx_steady = (phase == 2);
			rx_steady = (phase == 2);
			sent = 0;
			while (sent < FRAMES_PER_PHASE) begin
				play = ($urandom_range(3) != 0);
				run_len = $urandom_range(1, 40);
				for (int i = 0; i < run_len && sent < FRAMES_PER_PHASE; i++) begin
					// back the receiver off while frames keep coming
					if (phase == 3 && sent == 40)
						rx_hold_req = 1'b1;
					// stop sending until the core has drained completely
					if (phase == 4 && sent == 80)
						wait_idle();
					send_frame(play, $urandom_range(15) == 0, random_chans());
					sent++;
				end
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && words_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
